// ----- hdl/bba_pkg.sv -----
// bba_pkg: sizes, storage layout, codes and helper functions of the buddy block allocator
// no dependencies; every other file of the allocator but bba_ram takes its names from here
package bba_pkg;

  localparam int unsigned TOP_ORDER  = 10;
  localparam int unsigned UNIT_BYTES = 16;
  localparam int unsigned UNITS      = 1 << TOP_ORDER;

  localparam int unsigned IDX_W    = 10;
  localparam int unsigned ORD_W    = 4;
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned HDR_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam logic [HDR_W-1:0] HDR_RESET = 8'd16;

  // free marks and start bits are packed into 32-bit rows
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WB        = 5;

  // rows used by the free marks of one order
  function automatic int unsigned words_of(int unsigned k);
    int unsigned blocks;
    blocks = 1 << (TOP_ORDER - k);
    return (blocks > WORD_BITS) ? blocks / WORD_BITS : 1;
  endfunction

  function automatic int unsigned mark_rows();
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k <= TOP_ORDER; k++) begin
      acc += words_of(k);
    end
    return acc;
  endfunction

  localparam int unsigned MARK_ROWS  = mark_rows();
  localparam int unsigned START_ROWS = (UNITS > WORD_BITS) ? UNITS / WORD_BITS : 1;
  localparam int unsigned START_BASE = MARK_ROWS;
  localparam int unsigned ROWS       = MARK_ROWS + START_ROWS;
  localparam int unsigned ROW_W      = $clog2(ROWS);

  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ORD_W-1:0]     ord_t;
  typedef logic [WB-1:0]        pos_t;
  typedef row_t                 base_tab_t [0:TOP_ORDER];

  function automatic base_tab_t base_tab();
    base_tab_t   t;
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k <= TOP_ORDER; k++) begin
      t[k] = ROW_W'(acc);
      acc += words_of(k);
    end
    return t;
  endfunction

  // first row of each order's free marks
  localparam base_tab_t ORDER_BASE = base_tab();

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_BAD_FREE  = 3'd4
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_ATAKE,
    S_ASPLIT,
    S_AMARK,
    S_FCHK,
    S_FMERGE,
    S_DONE
  } state_e;

  // read/write request to the mark store
  typedef struct packed {
    logic  rd_en;
    row_t  rd_row;
    logic  wr_en;
    row_t  wr_row;
    word_t wr_data;
  } mem_req_t;

  // smallest nonempty order at or above the needed one
  typedef struct packed {
    logic found;
    ord_t order;
    pos_t word;
  } srch_t;

  typedef struct packed {
    row_t row;
    pos_t pos;
  } loc_t;

  function automatic pos_t lowest_set(word_t w);
    pos_t p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) p = WB'(i);
    end
    return p;
  endfunction

endpackage

// ----- hdl/bba_req_if.sv -----
// bba_req_if: request channel of the buddy block allocator, valid/ready with payload
// depends on bba_pkg for field widths
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [bba_pkg::BYTES_W-1:0] request_bytes;
  logic [bba_pkg::IDX_W-1:0]   free_index;

  modport source (output valid, req_type, request_bytes, free_index, input ready);
  modport sink   (input valid, req_type, request_bytes, free_index, output ready);
endinterface

// ----- hdl/bba_rsp_if.sv -----
// bba_rsp_if: result channel of the buddy block allocator, valid/ready with payload
// depends on bba_pkg for field widths
interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::STATUS_W-1:0] status;
  logic [bba_pkg::IDX_W-1:0]    block_index;
  logic [bba_pkg::ORD_W-1:0]    block_order;

  modport source (output valid, status, block_index, block_order, input ready);
  modport sink   (input valid, status, block_index, block_order, output ready);
endinterface

// ----- hdl/bba_ram.sv -----
// bba_ram: generic single-write, single-read memory with registered read data
// no dependencies
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hdl/bba_size_calc.sv -----
// bba_size_calc: adds the header to a request and finds the smallest fitting order
// depends on bba_pkg
module bba_size_calc (
  input  logic [bba_pkg::BYTES_W-1:0] bytes_i,
  input  logic [bba_pkg::HDR_W-1:0]   header_i,
  output logic                        zero_o,
  output logic                        too_large_o,
  output bba_pkg::ord_t               need_o
);
  localparam int unsigned TOT_W = bba_pkg::BYTES_W + 1;

  logic [TOT_W-1:0]           total;
  logic [bba_pkg::TOP_ORDER:0] fits;

  assign total = TOT_W'(bytes_i) + TOT_W'(header_i);

  // one compare per order against the block size
  always_comb begin
    for (int k = 0; k <= bba_pkg::TOP_ORDER; k++) begin
      fits[k] = (64'(total) <= (64'(bba_pkg::UNIT_BYTES) << k));
    end
  end

  always_comb begin
    need_o = '0;
    for (int k = bba_pkg::TOP_ORDER; k >= 0; k--) begin
      if (fits[k]) need_o = bba_pkg::ORD_W'(k);
    end
  end

  assign zero_o      = (bytes_i == '0);
  assign too_large_o = ~|fits;
endmodule

// ----- hdl/bba_mark_store.sv -----
// bba_mark_store: memory of free marks and start bits, row valid and nonzero flags, search
// depends on bba_pkg and bba_ram
module bba_mark_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bba_pkg::mem_req_t req_i,
  output bba_pkg::word_t    rd_data_o,
  input  bba_pkg::ord_t     need_i,
  output bba_pkg::srch_t    srch_o
);
  localparam bba_pkg::row_t TOP_ROW = bba_pkg::ORDER_BASE[bba_pkg::TOP_ORDER];
  localparam logic [bba_pkg::ROWS-1:0] NZ_RESET =
    {{(bba_pkg::ROWS-1){1'b0}}, 1'b1} << TOP_ROW;

  logic [bba_pkg::ROWS-1:0]    valid_q;
  logic [bba_pkg::ROWS-1:0]    nz_q;
  bba_pkg::row_t               rd_row_q;
  bba_pkg::word_t              ram_data;
  logic [bba_pkg::TOP_ORDER:0] nonempty;
  bba_pkg::pos_t               first_word [0:bba_pkg::TOP_ORDER];

  bba_ram #(
    .WIDTH (bba_pkg::WORD_BITS),
    .DEPTH (bba_pkg::ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_row),
    .wdata_i (req_i.wr_data),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_row),
    .rdata_o (ram_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q          <= '0;
      nz_q             <= NZ_RESET;
      rd_row_q         <= '0;
    end else begin
      if (req_i.rd_en) rd_row_q <= req_i.rd_row;
      if (req_i.wr_en) begin
        valid_q[req_i.wr_row] <= 1'b1;
        nz_q[req_i.wr_row]    <= |req_i.wr_data;
      end
    end
  end

  // a row never written reads as its reset contents
  always_comb begin
    if (valid_q[rd_row_q]) begin
      rd_data_o = ram_data;
    end else begin
      rd_data_o = (rd_row_q == TOP_ROW) ? bba_pkg::word_t'(1) : '0;
    end
  end

  for (genvar k = 0; k <= bba_pkg::TOP_ORDER; k++) begin : g_order
    localparam int unsigned B = bba_pkg::ORDER_BASE[k];
    localparam int unsigned N = bba_pkg::words_of(k);
    logic [N-1:0] rows_nz;
    assign rows_nz       = nz_q[B +: N];
    assign nonempty[k]   = |rows_nz;
    assign first_word[k] = bba_pkg::lowest_set(bba_pkg::word_t'(rows_nz));
  end

  always_comb begin
    srch_o = '0;
    for (int k = bba_pkg::TOP_ORDER; k >= 0; k--) begin
      if (nonempty[k] && (k >= int'(need_i))) begin
        srch_o.found = 1'b1;
        srch_o.order = bba_pkg::ORD_W'(k);
      end
    end
    srch_o.word = first_word[srch_o.order];
  end
endmodule

// ----- hdl/buddy_block_allocator_unit.sv -----
// buddy_block_allocator_unit: top level of the buddy allocator over 2^TOP_ORDER units
// depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ram, bba_size_calc, bba_mark_store
//
// channel   kind        handshake         carries
// req_i     sink        valid/ready       req_type, request_bytes, free_index
// rsp_o     source      valid/ready       status, block_index, block_order
// cfg       write only  cfg_we_i          header_bytes on cfg_wdata_i
//
// one request at a time; a rejected allocate skips the walk over the orders, while a granted
// allocate or a free walks them with one mark row read-modify-write per order per cycle
// reset leaves one free block of the top order and no allocated block, no sweep needed
// a finished result waits in the output register while the next request is accepted;
// only the final handoff of that next request waits for the register to empty
module buddy_block_allocator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::HDR_W-1:0] cfg_wdata_i,
  bba_req_if.sink                   req_i,
  bba_rsp_if.source                 rsp_o
);
  localparam int unsigned OAW = $clog2(bba_pkg::UNITS);

  bba_pkg::state_e           state_q, state_d;
  logic [bba_pkg::HDR_W-1:0] header_q;
  bba_pkg::ord_t             need_q, need_d;
  bba_pkg::ord_t             cur_q, cur_d;
  bba_pkg::pos_t             word_q, word_d;
  bba_pkg::idx_t             idx_q, idx_d;
  bba_pkg::status_e          res_st_q, res_st_d;
  bba_pkg::idx_t             res_idx_q, res_idx_d;
  bba_pkg::ord_t             res_ord_q, res_ord_d;
  logic                      out_valid_q, out_valid_d;
  bba_pkg::status_e          out_st_q;
  bba_pkg::idx_t             out_idx_q;
  bba_pkg::ord_t             out_ord_q;
  logic                      out_load;

  bba_pkg::mem_req_t mreq;
  bba_pkg::word_t    rd_data;
  bba_pkg::srch_t    srch;
  logic              sz_zero, sz_too_large;
  bba_pkg::ord_t     sz_need;
  logic              ord_we, ord_re;
  bba_pkg::ord_t     ord_rdata;

  // tree position of the block of order k that holds unit u
  function automatic bba_pkg::loc_t mark_loc(bba_pkg::ord_t k, bba_pkg::idx_t u);
    bba_pkg::idx_t blk;
    bba_pkg::loc_t l;
    blk   = u >> k;
    l.row = bba_pkg::ORDER_BASE[k] + bba_pkg::row_t'(blk >> bba_pkg::WB);
    l.pos = blk[bba_pkg::WB-1:0];
    return l;
  endfunction

  function automatic bba_pkg::loc_t start_loc(bba_pkg::idx_t u);
    bba_pkg::loc_t l;
    l.row = bba_pkg::row_t'(bba_pkg::START_BASE) + bba_pkg::row_t'(u >> bba_pkg::WB);
    l.pos = u[bba_pkg::WB-1:0];
    return l;
  endfunction

  bba_size_calc u_size (
    .bytes_i     (req_i.request_bytes),
    .header_i    (header_q),
    .zero_o      (sz_zero),
    .too_large_o (sz_too_large),
    .need_o      (sz_need)
  );

  bba_mark_store u_marks (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mreq),
    .rd_data_o (rd_data),
    .need_i    (need_q),
    .srch_o    (srch)
  );

  // order of each allocated block, used only where its start bit is set
  bba_ram #(
    .WIDTH (bba_pkg::ORD_W),
    .DEPTH (bba_pkg::UNITS)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (idx_q[OAW-1:0]),
    .wdata_i (need_q),
    .re_i    (ord_re),
    .raddr_i (req_i.free_index[OAW-1:0]),
    .rdata_o (ord_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bba_pkg::S_IDLE;
      header_q    <= bba_pkg::HDR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) header_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    need_q    <= need_d;
    cur_q     <= cur_d;
    word_q    <= word_d;
    idx_q     <= idx_d;
    res_st_q  <= res_st_d;
    res_idx_q <= res_idx_d;
    res_ord_q <= res_ord_d;
    if (out_load) begin
      out_st_q  <= res_st_q;
      out_idx_q <= res_idx_q;
      out_ord_q <= res_ord_q;
    end
  end

  always_comb begin
    bba_pkg::loc_t la;
    bba_pkg::loc_t lb;
    bba_pkg::idx_t u;
    bba_pkg::idx_t blk;
    bba_pkg::pos_t pos;
    bba_pkg::ord_t k;
    bba_pkg::ord_t kn;

    state_d     = state_q;
    need_d      = need_q;
    cur_d       = cur_q;
    word_d      = word_q;
    idx_d       = idx_q;
    res_st_d    = res_st_q;
    res_idx_d   = res_idx_q;
    res_ord_d   = res_ord_q;
    mreq        = '0;
    ord_we      = 1'b0;
    ord_re      = 1'b0;
    req_i.ready = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;
    la          = '0;
    lb          = '0;
    u           = '0;
    blk         = '0;
    pos         = '0;
    k           = '0;
    kn          = '0;

    case (state_q)
      bba_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        res_idx_d   = '0;
        res_ord_d   = '0;
        if (req_i.valid) begin
          if (req_i.req_type == bba_pkg::REQ_FREE) begin
            idx_d = req_i.free_index;
            if ({1'b0, req_i.free_index} >= (bba_pkg::IDX_W + 1)'(bba_pkg::UNITS)) begin
              res_st_d = bba_pkg::ST_BAD_FREE;
              state_d  = bba_pkg::S_DONE;
            end else begin
              // start bit and order of the block are fetched together
              la          = start_loc(req_i.free_index);
              mreq.rd_en  = 1'b1;
              mreq.rd_row = la.row;
              ord_re      = 1'b1;
              state_d     = bba_pkg::S_FCHK;
            end
          end else if (sz_zero) begin
            res_st_d = bba_pkg::ST_ZERO;
            state_d  = bba_pkg::S_DONE;
          end else if (sz_too_large) begin
            res_st_d = bba_pkg::ST_TOO_LARGE;
            state_d  = bba_pkg::S_DONE;
          end else begin
            need_d  = sz_need;
            state_d = bba_pkg::S_FIND;
          end
        end
      end

      bba_pkg::S_FIND: begin
        if (!srch.found) begin
          res_st_d = bba_pkg::ST_NO_MEM;
          state_d  = bba_pkg::S_DONE;
        end else begin
          cur_d       = srch.order;
          word_d      = srch.word;
          mreq.rd_en  = 1'b1;
          mreq.rd_row = bba_pkg::ORDER_BASE[srch.order] + bba_pkg::row_t'(srch.word);
          state_d     = bba_pkg::S_ATAKE;
        end
      end

      bba_pkg::S_ATAKE: begin
        // lowest free block in the first nonempty row of the order
        pos          = bba_pkg::lowest_set(rd_data);
        blk          = (bba_pkg::idx_t'(word_q) << bba_pkg::WB) | bba_pkg::idx_t'(pos);
        u            = blk << cur_q;
        idx_d        = u;
        mreq.wr_en   = 1'b1;
        mreq.wr_row  = bba_pkg::ORDER_BASE[cur_q] + bba_pkg::row_t'(word_q);
        mreq.wr_data = rd_data & ~(bba_pkg::word_t'(1) << pos);
        mreq.rd_en   = 1'b1;
        if (cur_q > need_q) begin
          kn          = cur_q - 1'b1;
          lb          = mark_loc(kn, u + (bba_pkg::idx_t'(1) << kn));
          mreq.rd_row = lb.row;
          cur_d       = kn;
          state_d     = bba_pkg::S_ASPLIT;
        end else begin
          lb          = start_loc(u);
          mreq.rd_row = lb.row;
          state_d     = bba_pkg::S_AMARK;
        end
      end

      bba_pkg::S_ASPLIT: begin
        // upper half of the split becomes free at this order
        la           = mark_loc(cur_q, idx_q + (bba_pkg::idx_t'(1) << cur_q));
        mreq.wr_en   = 1'b1;
        mreq.wr_row  = la.row;
        mreq.wr_data = rd_data | (bba_pkg::word_t'(1) << la.pos);
        mreq.rd_en   = 1'b1;
        if (cur_q > need_q) begin
          kn          = cur_q - 1'b1;
          lb          = mark_loc(kn, idx_q + (bba_pkg::idx_t'(1) << kn));
          mreq.rd_row = lb.row;
          cur_d       = kn;
        end else begin
          lb          = start_loc(idx_q);
          mreq.rd_row = lb.row;
          state_d     = bba_pkg::S_AMARK;
        end
      end

      bba_pkg::S_AMARK: begin
        la           = start_loc(idx_q);
        mreq.wr_en   = 1'b1;
        mreq.wr_row  = la.row;
        mreq.wr_data = rd_data | (bba_pkg::word_t'(1) << la.pos);
        ord_we       = 1'b1;
        res_st_d     = bba_pkg::ST_OK;
        res_idx_d    = idx_q;
        res_ord_d    = need_q;
        state_d      = bba_pkg::S_DONE;
      end

      bba_pkg::S_FCHK: begin
        la = start_loc(idx_q);
        if (!rd_data[la.pos]) begin
          res_st_d = bba_pkg::ST_BAD_FREE;
          state_d  = bba_pkg::S_DONE;
        end else begin
          mreq.wr_en   = 1'b1;
          mreq.wr_row  = la.row;
          mreq.wr_data = rd_data & ~(bba_pkg::word_t'(1) << la.pos);
          k = (ord_rdata > bba_pkg::ORD_W'(bba_pkg::TOP_ORDER)) ?
              bba_pkg::ORD_W'(bba_pkg::TOP_ORDER) : ord_rdata;
          u     = idx_q & ~((bba_pkg::idx_t'(1) << k) - 1'b1);
          idx_d = u;
          cur_d = k;
          if (k < bba_pkg::ORD_W'(bba_pkg::TOP_ORDER)) begin
            lb          = mark_loc(k, u ^ (bba_pkg::idx_t'(1) << k));
            mreq.rd_en  = 1'b1;
            mreq.rd_row = lb.row;
          end
          state_d = bba_pkg::S_FMERGE;
        end
      end

      bba_pkg::S_FMERGE: begin
        if (cur_q == bba_pkg::ORD_W'(bba_pkg::TOP_ORDER)) begin
          // the top order row holds a single mark
          mreq.wr_en   = 1'b1;
          mreq.wr_row  = bba_pkg::ORDER_BASE[bba_pkg::TOP_ORDER];
          mreq.wr_data = bba_pkg::word_t'(1);
          res_st_d     = bba_pkg::ST_OK;
          res_idx_d    = idx_q;
          res_ord_d    = cur_q;
          state_d      = bba_pkg::S_DONE;
        end else begin
          lb = mark_loc(cur_q, idx_q ^ (bba_pkg::idx_t'(1) << cur_q));
          mreq.wr_en  = 1'b1;
          mreq.wr_row = lb.row;
          if (rd_data[lb.pos]) begin
            // buddy free: absorb it and climb one order
            mreq.wr_data = rd_data & ~(bba_pkg::word_t'(1) << lb.pos);
            u     = idx_q & ~(bba_pkg::idx_t'(1) << cur_q);
            kn    = cur_q + 1'b1;
            idx_d = u;
            cur_d = kn;
            if (kn < bba_pkg::ORD_W'(bba_pkg::TOP_ORDER)) begin
              la          = mark_loc(kn, u ^ (bba_pkg::idx_t'(1) << kn));
              mreq.rd_en  = 1'b1;
              mreq.rd_row = la.row;
            end
          end else begin
            // buddy shares the row, so the merged block is marked in the same write
            la           = mark_loc(cur_q, idx_q);
            mreq.wr_data = rd_data | (bba_pkg::word_t'(1) << la.pos);
            res_st_d     = bba_pkg::ST_OK;
            res_idx_d    = idx_q;
            res_ord_d    = cur_q;
            state_d      = bba_pkg::S_DONE;
          end
        end
      end

      bba_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = bba_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bba_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.block_index = out_idx_q;
  assign rsp_o.block_order = out_ord_q;
endmodule

// ----- tb/tb_chan_if.sv -----
// tb_chan_if: request and result transaction types that the testbench queues and predicts
// depends on bba_pkg
package tb_bba_pkg;
  import bba_pkg::*;

  typedef struct packed {
    req_type_e             kind;
    logic [BYTES_W-1:0]    nbytes;
    idx_t                  index;
  } req_item_t;

  typedef struct packed {
    status_e st;
    idx_t    index;
    ord_t    order;
  } rsp_item_t;
endpackage

// ----- tb/tb.sv -----
// tb: self-checking testbench of buddy_block_allocator_unit
// depends on bba_pkg, bba_req_if, bba_rsp_if, tb_bba_pkg and the allocator rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;
  import tb_bba_pkg::*;

  localparam int unsigned NODE_CNT  = (2 << TOP_ORDER) - 1;
  localparam int unsigned WATCH_MAX = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [HDR_W-1:0] cfg_wdata_i = '0;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  buddy_block_allocator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow allocator state
  logic [HDR_W-1:0] hdr_bytes;
  bit               free_mark [NODE_CNT];
  bit               alloc_start [UNITS];
  ord_t             alloc_order [UNITS];
  idx_t             live_blocks [$];

  req_item_t pending_reqs [$];
  rsp_item_t expected_rsps [$];

  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  bit req_taken;
  int mismatches, watch_cnt;
  bit done;

  function automatic int unsigned tree_slot(int unsigned k, int unsigned u);
    return ((1 << (TOP_ORDER - k)) - 1) + (u >> k);
  endfunction

  function automatic void shadow_reset();
    foreach (free_mark[i]) free_mark[i] = 0;
    foreach (alloc_start[i]) begin
      alloc_start[i] = 0;
      alloc_order[i] = '0;
    end
    free_mark[tree_slot(TOP_ORDER, 0)] = 1;
    hdr_bytes = HDR_RESET;
    live_blocks.delete();
  endfunction

  // allocate: smallest fitting order, lowest-address block of smallest nonempty order
  function automatic rsp_item_t predict_alloc(logic [BYTES_W-1:0] nbytes);
    rsp_item_t   r;
    int unsigned total, need, cur, idx;
    bit          found;
    r = '{ST_OK, '0, '0};
    found = 0;
    cur = 0;
    idx = 0;
    if (nbytes == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    total = nbytes + hdr_bytes;
    need = 0;
    while (need <= TOP_ORDER && (UNIT_BYTES << need) < total) need++;
    if (need > TOP_ORDER) begin
      r.st = ST_TOO_LARGE;
      return r;
    end
    for (int unsigned k = need; k <= TOP_ORDER && !found; k++) begin
      for (int unsigned b = 0; b < (1 << (TOP_ORDER - k)); b++) begin
        if (free_mark[tree_slot(k, b << k)]) begin
          cur = k;
          idx = b << k;
          found = 1;
          break;
        end
      end
    end
    if (!found) begin
      r.st = ST_NO_MEM;
      return r;
    end
    free_mark[tree_slot(cur, idx)] = 0;
    while (cur > need) begin
      cur--;
      free_mark[tree_slot(cur, idx + (1 << cur))] = 1;
    end
    alloc_start[idx] = 1;
    alloc_order[idx] = ord_t'(need);
    live_blocks.push_back(idx_t'(idx));
    r.index = idx_t'(idx);
    r.order = ord_t'(need);
    return r;
  endfunction

  // free: release and merge with the xor buddy while it is free
  function automatic rsp_item_t predict_free(idx_t index);
    rsp_item_t   r;
    int unsigned k, idx, bud;
    r = '{ST_OK, '0, '0};
    idx = index;
    if (!alloc_start[idx]) begin
      r.st = ST_BAD_FREE;
      return r;
    end
    alloc_start[idx] = 0;
    k = alloc_order[idx];
    foreach (live_blocks[i]) if (live_blocks[i] == index) begin
      live_blocks.delete(i);
      break;
    end
    while (k < TOP_ORDER) begin
      bud = idx ^ (1 << k);
      if (!free_mark[tree_slot(k, bud)]) break;
      free_mark[tree_slot(k, bud)] = 0;
      idx &= ~(1 << k);
      k++;
    end
    free_mark[tree_slot(k, idx)] = 1;
    r.index = idx_t'(idx);
    r.order = ord_t'(k);
    return r;
  endfunction

  // driver: offered transaction held until accepted, next one offered at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_ch.valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid         <= 1'b1;
          req_ch.req_type      <= pending_reqs[0].kind;
          req_ch.request_bytes <= pending_reqs[0].nbytes;
          req_ch.free_index    <= pending_reqs[0].index;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict each accepted request, compare each result with the oldest expectation
  always @(posedge clk_i) begin
    rsp_item_t exp_r;
    req_taken = 1'b0;
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        watch_cnt <= 0;
      else
        watch_cnt <= watch_cnt + 1;
      if (req_ch.valid && req_ch.ready) begin
        req_taken = 1'b1;
        if (req_ch.req_type == REQ_ALLOC)
          expected_rsps.push_back(predict_alloc(req_ch.request_bytes));
        else
          expected_rsps.push_back(predict_free(req_ch.free_index));
        void'(pending_reqs.pop_front());
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result status %0d", rsp_ch.status);
        end else begin
          exp_r = expected_rsps.pop_front();
          if (rsp_ch.status !== exp_r.st || rsp_ch.block_index !== exp_r.index ||
              rsp_ch.block_order !== exp_r.order) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d idx %0d ord %0d, got st %0d idx %0d ord %0d",
                       exp_r.st, exp_r.index, exp_r.order, rsp_ch.status,
                       rsp_ch.block_index, rsp_ch.block_order);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (watch_cnt >= WATCH_MAX && !done) begin
      $display("tb: failure");
      $finish;
    end
  end

  // wait until every queued request has been answered, then let the pipe settle
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_header(logic [HDR_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    hdr_bytes    = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_alloc(logic [BYTES_W-1:0] nbytes);
    pending_reqs.push_back('{REQ_ALLOC, nbytes, idx_t'($urandom)});
  endfunction

  function automatic void add_free(idx_t index);
    pending_reqs.push_back('{REQ_FREE, 16'($urandom), index});
  endfunction

  // mostly sizes of a few units, frees of live blocks, some noise
  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: add_alloc(16'($urandom));
        1: add_free(idx_t'($urandom));
        2, 3, 4: add_alloc(16'($urandom_range(1, 300)));
        5: add_alloc(16'($urandom_range(1, 4000)));
        default: begin
          // drain so live block list is current, then free one
          drain();
          if (live_blocks.size() != 0)
            add_free(live_blocks[$urandom_range(live_blocks.size() - 1)]);
          else
            add_alloc(16'($urandom_range(1, 64)));
        end
      endcase
    end
    drain();
  endtask

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.free_index    = '0;
    rsp_ch.ready         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off   = 0;
    req_taken  = 0;
    mismatches = 0;
    watch_cnt  = 0;
    done       = 0;
    shadow_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: every status, size extremes, whole-memory block, merges
    add_alloc(16'd0);
    add_alloc(16'hFFFF);
    add_alloc(16'd1);
    add_alloc(16'd16);
    add_alloc(16'd17);
    add_alloc(16'd100);
    add_free(10'd0);
    add_free(10'd0);
    add_free(10'd1023);
    add_free(10'd2);
    add_free(10'd4);
    add_alloc(16'd16368);
    add_alloc(16'd1);
    add_free(10'd0);
    add_alloc(16'd16369);
    drain();
    write_header(8'd0);
    add_alloc(16'd16384);
    add_alloc(16'd1);
    add_free(10'd0);
    add_alloc(16'd16);
    add_alloc(16'd16);
    add_free(10'd1);
    add_free(10'd0);
    drain();
    write_header(8'd255);
    add_alloc(16'd16129);
    add_alloc(16'd16130);
    add_alloc(16'd1);
    drain();

    // random phases over idling styles and header settings
    write_header(8'd16);
    random_phase(150);
    send_idle_pct = 82;
    write_header(8'($urandom));
    random_phase(120);
    send_idle_pct = 0;
    recv_stall_pct = 82;
    write_header(8'd0);
    random_phase(120);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    write_header(8'd255);
    random_phase(150);

    // long receiver hold-off while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_header(8'd8);
    hold_off = 1;
    for (int i = 0; i < 20; i++) add_alloc(16'($urandom_range(1, 200)));
    repeat (300) @(posedge clk_i);
    hold_off = 0;
    drain();
    random_phase(250);

    done = 1;
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/bba_pkg.sv
hdl/bba_req_if.sv
hdl/bba_rsp_if.sv
hdl/bba_ram.sv
hdl/bba_size_calc.sv
hdl/bba_mark_store.sv
hdl/buddy_block_allocator_unit.sv
tb/tb_chan_if.sv
tb/tb.sv
